### hw/rtl/v3a_pkg.sv
package v3a_pkg;

    // default number of fraction bits of the fixed point format
    localparam int FRAC_BITS_DEF = 16;

    // operation codes
    localparam logic [3:0] FN_LEN   = 4'd0;
    localparam logic [3:0] FN_LENSQ = 4'd1;
    localparam logic [3:0] FN_NEG   = 4'd2;
    localparam logic [3:0] FN_DOT   = 4'd3;
    localparam logic [3:0] FN_CROSS = 4'd4;
    localparam logic [3:0] FN_ADD   = 4'd5;
    localparam logic [3:0] FN_SUB   = 4'd6;
    localparam logic [3:0] FN_SCALE = 4'd7;
    localparam logic [3:0] FN_DIV   = 4'd8;
    localparam logic [3:0] FN_PROJ  = 4'd9;

    // divider: 96-bit dividend, 64-bit divisor, 34 quotient bits
    localparam int DIV_NW = 96;
    localparam int DIV_DW = 64;
    localparam int DIV_QB = 34;

    // square root: 64-bit radicand, one root bit per stage
    localparam int SQRT_RW    = 32;
    localparam int SQRT_RAD_W = 2 * SQRT_RW;

endpackage

### hw/rtl/vector3_arithmetic_unit.sv
// Pipeline: 5 front stages, 34 divider stages and 1 output register lie between an
// accepted word and its result word; the divider chain sets the depth.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Reset (synchronous, active low) clears the stage valid bits only; data
// registers are not reset.
module vector3_arithmetic_unit
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_factor,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_res_x,
    output logic signed [31:0] o_res_y,
    output logic signed [31:0] o_res_z,
    output logic signed [31:0] o_res_scalar,
    output logic               o_div_zero,
    output logic               o_overflow
);

    localparam int LAT     = 5 + DIV_QB + 1;
    localparam int ROOT_DL = DIV_QB - SQRT_RW;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        logic [3:0]       func;
        logic [2:0][31:0] b;
        logic [2:0][31:0] res;
        logic [31:0]      sc;
        logic             ovf;
        logic [2:0]       qneg;
        logic [2:0]       dsat;
        logic             fzero;
        logic             azero;
    } t_side;

    // saturate a sign and magnitude pair
    function automatic t_sat sat_mag(input logic neg, input logic [65:0] mag);
        t_sat s;
        s.ovf = 1'b0;
        if (neg) begin
            if (mag > 66'h8000_0000) begin
                s.ovf = 1'b1;
                s.val = 32'h8000_0000;
            end else begin
                s.val = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > 66'h7FFF_FFFF) begin
                s.ovf = 1'b1;
                s.val = 32'h7FFF_FFFF;
            end else begin
                s.val = mag[31:0];
            end
        end
        return s;
    endfunction

    // saturate a two's complement value
    function automatic t_sat sat_signed(input logic [66:0] v);
        t_sat s;
        s.ovf = !((&v[66:31]) || !(|v[66:31]));
        if (s.ovf) begin
            s.val = v[66] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            s.val = v[31:0];
        end
        return s;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    // global pipeline advance
    logic [LAT-1:0] r_vld;
    logic           pipe_en;

    assign pipe_en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !pipe_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage 1: input register
    logic [3:0]         r1_func;
    logic signed [31:0] r1_a [3];
    logic signed [31:0] r1_b [3];
    logic signed [31:0] r1_f;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_func <= i_func;
            r1_a[0] <= i_a_x;
            r1_a[1] <= i_a_y;
            r1_a[2] <= i_a_z;
            r1_b[0] <= i_b_x;
            r1_b[1] <= i_b_y;
            r1_b[2] <= i_b_z;
            r1_f    <= i_factor;
        end
    end

    // stage 2: six shared multipliers, linear ops
    logic signed [31:0] mx [6];
    logic signed [31:0] my [6];
    logic signed [32:0] n_lin [3];

    always_comb begin
        if (r1_func == FN_CROSS) begin
            mx[0] = r1_a[1]; my[0] = r1_b[2];
            mx[1] = r1_a[2]; my[1] = r1_b[1];
            mx[2] = r1_a[2]; my[2] = r1_b[0];
            mx[3] = r1_a[0]; my[3] = r1_b[2];
            mx[4] = r1_a[0]; my[4] = r1_b[1];
            mx[5] = r1_a[1]; my[5] = r1_b[0];
        end else begin
            for (int i = 0; i < 3; i++) begin
                mx[i]   = r1_a[i];
                my[i]   = r1_a[i];
                mx[3+i] = r1_a[i];
                my[3+i] = (r1_func == FN_SCALE) ? r1_f : r1_b[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            case (r1_func)
                FN_NEG:  n_lin[i] = 33'sd0 - 33'(r1_a[i]);
                FN_ADD:  n_lin[i] = 33'(r1_a[i]) + 33'(r1_b[i]);
                FN_SUB:  n_lin[i] = 33'(r1_a[i]) - 33'(r1_b[i]);
                default: n_lin[i] = '0;
            endcase
        end
    end

    logic [3:0]         r2_func;
    logic signed [63:0] r2_p [6];
    logic signed [32:0] r2_lin [3];
    logic signed [31:0] r2_a [3];
    logic signed [31:0] r2_b [3];
    logic signed [31:0] r2_f;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_func <= r1_func;
            r2_f    <= r1_f;
            for (int i = 0; i < 6; i++) r2_p[i] <= mx[i] * my[i];
            for (int i = 0; i < 3; i++) begin
                r2_lin[i] <= n_lin[i];
                r2_a[i]   <= r1_a[i];
                r2_b[i]   <= r1_b[i];
            end
        end
    end

    // stage 3: sums of products
    logic [3:0]         r3_func;
    logic [63:0]        r3_sq;
    logic signed [65:0] r3_dot;
    logic signed [64:0] r3_vec [3];
    logic signed [32:0] r3_lin [3];
    logic signed [31:0] r3_a [3];
    logic signed [31:0] r3_b [3];
    logic signed [31:0] r3_f;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_func <= r2_func;
            r3_f    <= r2_f;
            r3_sq   <= r2_p[0] + r2_p[1] + r2_p[2];
            r3_dot  <= 66'(r2_p[3]) + 66'(r2_p[4]) + 66'(r2_p[5]);
            for (int i = 0; i < 3; i++) begin
                r3_vec[i] <= (r2_func == FN_CROSS) ?
                             (65'(r2_p[2*i]) - 65'(r2_p[2*i+1])) : 65'(r2_p[3+i]);
                r3_lin[i] <= r2_lin[i];
                r3_a[i]   <= r2_a[i];
                r3_b[i]   <= r2_b[i];
            end
        end
    end

    // stage 4: final values of the direct ops, projection partial products
    logic [65:0] dmag_w;
    logic [31:0] amag [3];
    logic [2:0][31:0] n4_res;
    logic [31:0] n4_sc;
    logic        n4_ovf;

    always_comb begin
        t_sat s;
        s      = '0;
        dmag_w = r3_dot[65] ? (66'd0 - r3_dot) : r3_dot;
        for (int i = 0; i < 3; i++) amag[i] = mag32(r3_a[i]);
        n4_res = '0;
        n4_sc  = '0;
        n4_ovf = 1'b0;
        case (r3_func) inside
            FN_LENSQ: begin
                s      = sat_mag(1'b0, 66'(r3_sq >> FRAC_BITS));
                n4_sc  = s.val;
                n4_ovf = s.ovf;
            end
            FN_DOT: begin
                s      = sat_signed(67'(r3_dot >>> FRAC_BITS));
                n4_sc  = s.val;
                n4_ovf = s.ovf;
            end
            FN_CROSS, FN_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    s         = sat_signed(67'(r3_vec[i] >>> FRAC_BITS));
                    n4_res[i] = s.val;
                    n4_ovf    = n4_ovf | s.ovf;
                end
            end
            FN_NEG, FN_ADD, FN_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    s         = sat_signed(67'(r3_lin[i]));
                    n4_res[i] = s.val;
                    n4_ovf    = n4_ovf | s.ovf;
                end
            end
            default: ;
        endcase
    end

    logic [3:0]       r4_func;
    logic [63:0]      r4_sq;
    logic             r4_dneg;
    logic [31:0]      r4_amag [3];
    logic [2:0]       r4_aneg;
    logic [2:0][31:0] r4_b;
    logic [31:0]      r4_fmag;
    logic             r4_fneg;
    logic             r4_fzero;
    logic [63:0]      r4_pl [3];
    logic [63:0]      r4_ph [3];
    logic [2:0][31:0] r4_res;
    logic [31:0]      r4_sc;
    logic             r4_ovf;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_func  <= r3_func;
            r4_sq    <= r3_sq;
            r4_dneg  <= r3_dot[65];
            r4_fmag  <= mag32(r3_f);
            r4_fneg  <= r3_f[31];
            r4_fzero <= (r3_f == 32'sd0);
            r4_res   <= n4_res;
            r4_sc    <= n4_sc;
            r4_ovf   <= n4_ovf;
            for (int i = 0; i < 3; i++) begin
                r4_amag[i] <= amag[i];
                r4_aneg[i] <= r3_a[i][31];
                r4_b[i]    <= r3_b[i];
                r4_pl[i]   <= amag[i] * dmag_w[31:0];
                r4_ph[i]   <= amag[i] * dmag_w[63:32];
            end
        end
    end

    // stage 5: divider operands
    logic [DIV_NW-1:0] n5_dnum [3];
    logic [DIV_NW-1:0] n5_dlim;
    t_side             n5_side;

    always_comb begin
        n5_dlim = DIV_NW'(r4_fmag) << DIV_QB;
        n5_side.func  = r4_func;
        n5_side.b     = r4_b;
        n5_side.res   = r4_res;
        n5_side.sc    = r4_sc;
        n5_side.ovf   = r4_ovf;
        n5_side.fzero = r4_fzero;
        n5_side.azero = (r4_sq == 64'd0);
        for (int i = 0; i < 3; i++) begin
            n5_dnum[i]      = DIV_NW'(r4_amag[i]) << FRAC_BITS;
            n5_side.dsat[i] = n5_dnum[i] >= n5_dlim;
            n5_side.qneg[i] = r4_aneg[i] ^ ((r4_func == FN_PROJ) ? r4_dneg : r4_fneg);
        end
    end

    logic [DIV_NW-1:0] r5_num [3];
    logic [DIV_DW-1:0] r5_den;
    logic [63:0]       r5_sq;
    t_side             r5_side;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_sq   <= r4_sq;
            r5_side <= n5_side;
            r5_den  <= (r4_func == FN_PROJ) ? r4_sq : DIV_DW'(r4_fmag);
            for (int i = 0; i < 3; i++) begin
                r5_num[i] <= (r4_func == FN_PROJ) ?
                             ({32'd0, r4_pl[i]} + {r4_ph[i], 32'd0}) : n5_dnum[i];
            end
        end
    end

    // iterative units: one shared divider per lane, one square root
    logic [DIV_QB-1:0]  quo [3];
    logic [SQRT_RW-1:0] root;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        v3a_div_pipe u_div (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_num (r5_num[g]),
            .i_den (r5_den),
            .o_quo (quo[g])
        );
    end

    v3a_sqrt_pipe u_sqrt (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_rad  (r5_sq),
        .o_root (root)
    );

    // side data and root delay matching the divider depth
    t_side              r_side [DIV_QB];
    logic [SQRT_RW-1:0] r_root_dly [ROOT_DL];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_side[0] <= r5_side;
            for (int k = 1; k < DIV_QB; k++) r_side[k] <= r_side[k-1];
            r_root_dly[0] <= root;
            for (int k = 1; k < ROOT_DL; k++) r_root_dly[k] <= r_root_dly[k-1];
        end
    end

    // output stage: finish root, divide and projection
    t_side            last;
    logic [2:0][31:0] n_res;
    logic [31:0]      n_sc;
    logic             n_ovf;
    logic             n_dz;

    always_comb begin
        t_sat s;
        s     = '0;
        last  = r_side[DIV_QB-1];
        n_res = last.res;
        n_sc  = last.sc;
        n_ovf = last.ovf;
        n_dz  = 1'b0;
        case (last.func)
            FN_LEN: begin
                s     = sat_mag(1'b0, 66'(r_root_dly[ROOT_DL-1]));
                n_sc  = s.val;
                n_ovf = s.ovf;
            end
            FN_DIV: begin
                if (last.fzero) begin
                    n_dz  = 1'b1;
                    n_res = '0;
                    n_ovf = 1'b0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (last.dsat[i]) begin
                            s = sat_mag(last.qneg[i], 66'h1_0000_0000);
                        end else begin
                            s = sat_mag(last.qneg[i] && (quo[i] != '0), 66'(quo[i]));
                        end
                        n_res[i] = s.val;
                        n_ovf    = n_ovf | s.ovf;
                    end
                end
            end
            FN_PROJ: begin
                if (last.azero) begin
                    n_res = last.b;
                    n_ovf = 1'b0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        s        = sat_mag(last.qneg[i] && (quo[i] != '0), 66'(quo[i]));
                        n_res[i] = s.val;
                        n_ovf    = n_ovf | s.ovf;
                    end
                end
            end
            default: ;
        endcase
    end

    logic [2:0][31:0] r_res;
    logic [31:0]      r_sc;
    logic             r_ovf;
    logic             r_dz;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_res <= n_res;
            r_sc  <= n_sc;
            r_ovf <= n_ovf;
            r_dz  <= n_dz;
        end
    end

    assign o_res_x      = r_res[0];
    assign o_res_y      = r_res[1];
    assign o_res_z      = r_res[2];
    assign o_res_scalar = r_sc;
    assign o_div_zero   = r_dz;
    assign o_overflow   = r_ovf;

`ifndef SYNTH
    // a divide by zero word carries a zero vector and no overflow
    a_divzero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |->
        (o_res_x == 32'sd0 && o_res_y == 32'sd0 && o_res_z == 32'sd0 && !o_overflow))
        else $error("div_zero word with nonzero fields");

    // scalar results never come with a vector result
    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res_scalar != 32'sd0) |->
        (o_res_x == 32'sd0 && o_res_y == 32'sd0 && o_res_z == 32'sd0))
        else $error("scalar and vector result both nonzero");

    // a stall freezes every stage valid bit
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule

### hw/rtl/v3a_div_pipe.sv
module v3a_div_pipe
    import v3a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QB-1:0] o_quo
);

    // restoring division, one quotient bit per stage; the upper dividend
    // bits must already be below the divisor
    logic [DIV_DW-1:0] r_rem [DIV_QB];
    logic [DIV_QB-1:0] r_low [DIV_QB];
    logic [DIV_DW-1:0] r_den [DIV_QB];
    logic [DIV_QB-1:0] r_quo [DIV_QB];

    for (genvar k = 0; k < DIV_QB; k++) begin : g_step
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_QB-1:0] low_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_QB-1:0] quo_in;
        logic [DIV_DW:0]   trial;
        logic [DIV_DW:0]   diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = {{(DIV_DW - (DIV_NW - DIV_QB)){1'b0}}, i_num[DIV_NW-1:DIV_QB]};
            assign low_in = i_num[DIV_QB-1:0];
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, low_in[DIV_QB-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                r_low[k] <= {low_in[DIV_QB-2:0], 1'b0};
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[DIV_QB-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[DIV_QB-1];

endmodule

### hw/rtl/v3a_sqrt_pipe.sv
module v3a_sqrt_pipe
    import v3a_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [SQRT_RAD_W-1:0] i_rad,
    output logic [SQRT_RW-1:0]    o_root
);

    // digit-by-digit integer square root, two radicand bits per stage
    logic [SQRT_RW+1:0]    r_rem  [SQRT_RW];
    logic [SQRT_RW-1:0]    r_root [SQRT_RW];
    logic [SQRT_RAD_W-1:0] r_rad  [SQRT_RW];

    for (genvar k = 0; k < SQRT_RW; k++) begin : g_step
        logic [SQRT_RW+1:0]    rem_in;
        logic [SQRT_RW-1:0]    root_in;
        logic [SQRT_RAD_W-1:0] rad_in;
        logic [SQRT_RW+3:0]    t;
        logic [SQRT_RW+3:0]    trial;
        logic [SQRT_RW+3:0]    diff;
        logic                  ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign t     = {rem_in, rad_in[SQRT_RAD_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = t - trial;
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[SQRT_RW+1:0] : t[SQRT_RW+1:0];
                r_root[k] <= {root_in[SQRT_RW-2:0], ge};
                r_rad[k]  <= {rad_in[SQRT_RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_RW-1];

endmodule
